// ===== design/text_console_writer_defines.svh =====
// Assertion macros for the text console writer.
// Used by the control module; expects clk_i and rst_ni in the including scope.
`ifndef TEXT_CONSOLE_WRITER_DEFINES_SVH
`define TEXT_CONSOLE_WRITER_DEFINES_SVH

// The property holds at every clock edge outside of reset.
`define TCW_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// The consequent holds in the cycle after the antecedent.
`define TCW_ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== design/tcw_pkg.sv =====
// Shared constants, codes and types of the text console writer.
// No dependencies; all design files but the macro header import it.
package tcw_pkg;

  // Screen geometry.
  localparam int COLUMNS    = 80;
  localparam int ROWS       = 25;
  localparam int CELL_COUNT = COLUMNS * ROWS;
  localparam int MOVE_COUNT = CELL_COUNT - COLUMNS;

  // Field widths of the request and result channels.
  localparam int OP_W   = 2;
  localparam int CHAR_W = 8;
  localparam int ATTR_W = 8;
  localparam int COL_W  = 7;
  localparam int ROW_W  = 5;
  localparam int POS_W  = 11;
  localparam int CELL_W = 16;

  // Internal widths: the column may sit one past the last column.
  localparam int ADDR_W = $clog2(CELL_COUNT);
  localparam int COLQ_W = $clog2(COLUMNS + 1);
  localparam int ROWQ_W = $clog2(ROWS);

  // Character codes.
  localparam logic [CHAR_W-1:0] CODE_NEWLINE = 8'h0A;
  localparam logic [CHAR_W-1:0] CODE_RETURN  = 8'h0D;
  localparam logic [CHAR_W-1:0] CODE_SPACE   = 8'h20;
  localparam logic [ATTR_W-1:0] RESET_ATTR   = 8'h07;

  typedef enum logic [OP_W-1:0] {
    OP_PUT   = 2'd0,
    OP_SET   = 2'd1,
    OP_CLEAR = 2'd2,
    OP_READ  = 2'd3
  } tcw_op_e;

  typedef struct packed {
    tcw_op_e             operation;
    logic [CHAR_W-1:0]   char_code;
    logic [COL_W-1:0]    cursor_column;
    logic [ROW_W-1:0]    cursor_row;
    logic [POS_W-1:0]    cell_index;
  } tcw_cmd_t;

  typedef struct packed {
    logic              we;
    logic [ADDR_W-1:0] waddr;
    logic [CELL_W-1:0] wdata;
    logic              re;
    logic [ADDR_W-1:0] raddr;
  } tcw_mem_req_t;

  typedef struct packed {
    logic [POS_W-1:0]  cursor_position;
    logic [CELL_W-1:0] cell_data;
  } tcw_result_t;

endpackage

// ===== design/tcw_if.sv =====
// Request and result channel interfaces of the text console writer.
// Depends on tcw_pkg for the field widths.
interface tcw_cmd_if import tcw_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [OP_W-1:0]   operation;
  logic [CHAR_W-1:0] char_code;
  logic [COL_W-1:0]  cursor_column;
  logic [ROW_W-1:0]  cursor_row;
  logic [POS_W-1:0]  cell_index;

  modport source (output valid, operation, char_code, cursor_column, cursor_row, cell_index,
                  input ready);
  modport sink   (input valid, operation, char_code, cursor_column, cursor_row, cell_index,
                  output ready);
endinterface

interface tcw_rsp_if import tcw_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [POS_W-1:0]  cursor_position;
  logic [CELL_W-1:0] cell_data;

  modport source (output valid, cursor_position, cell_data, input ready);
  modport sink   (input valid, cursor_position, cell_data, output ready);
endinterface

// ===== design/tcw_cell_ram.sv =====
// Screen cell memory: one write port and one registered read port.
// Depends on tcw_pkg for the memory geometry and the port struct.
module tcw_cell_ram import tcw_pkg::*; (
  input  logic              clk_i,
  input  tcw_mem_req_t      mem_i,
  output logic [CELL_W-1:0] rd_data_o
);

  logic [CELL_W-1:0] mem [CELL_COUNT];
  logic [CELL_W-1:0] rd_data_q;

  // Write and read in the same cycle go to different addresses by construction.
  always_ff @(posedge clk_i) begin
    if (mem_i.we) begin
      mem[mem_i.waddr] <= mem_i.wdata;
    end
    if (mem_i.re) begin
      rd_data_q <= mem[mem_i.raddr];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

// ===== design/tcw_ctrl.sv =====
// Console sequencer: cursor state, request decode, scroll and fill sweeps, and cell reads.
// Depends on tcw_pkg, the request channel interface and the assertion macros.
`include "text_console_writer_defines.svh"

module tcw_ctrl import tcw_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  tcw_cmd_if.sink           cmd_i,
  input  logic [ATTR_W-1:0] attr_i,
  output tcw_mem_req_t      mem_o,
  input  logic [CELL_W-1:0] rd_data_i,
  output logic              res_valid_o,
  output tcw_result_t       res_o,
  input  logic              res_ready_i
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EXEC,
    ST_SCROLL,
    ST_FILL,
    ST_READ,
    ST_RESP
  } state_e;

  state_e            state_q, state_d;
  state_e            after_q, after_d;
  logic [ADDR_W-1:0] cnt_q, cnt_d;
  logic [CELL_W-1:0] fill_val_q, fill_val_d;
  logic [COLQ_W-1:0] col_q, col_d;
  logic [ROWQ_W-1:0] row_q, row_d;
  logic [POS_W-1:0]  curs_q, curs_d;
  logic [CELL_W-1:0] data_q, data_d;
  tcw_cmd_t          cmd_q, cmd_d;
  tcw_cmd_t          cmd_in;
  tcw_mem_req_t      mem_req;
  logic              cmd_ready;
  logic              accept;

  // Linear position of a row and column, kept to the cursor register width.
  function automatic logic [POS_W-1:0] lin_pos(input logic [ROWQ_W:0] r,
                                               input logic [COLQ_W-1:0] c);
    logic [31:0] p;
    p = 32'(r) * 32'(COLUMNS) + 32'(c);
    return p[POS_W-1:0];
  endfunction

  // A new request is taken when idle, or while the previous result is handed off.
  assign cmd_ready   = (state_q == ST_IDLE) || ((state_q == ST_RESP) && res_ready_i);
  assign cmd_i.ready = cmd_ready;
  assign accept      = cmd_i.valid && cmd_ready;

  assign cmd_in.operation     = tcw_op_e'(cmd_i.operation);
  assign cmd_in.char_code     = cmd_i.char_code;
  assign cmd_in.cursor_column = cmd_i.cursor_column;
  assign cmd_in.cursor_row    = cmd_i.cursor_row;
  assign cmd_in.cell_index    = cmd_i.cell_index;

  // Next-state logic and memory request.
  always_comb begin
    logic [ROWQ_W:0]   r;
    logic [ROWQ_W:0]   r2;
    logic [COLQ_W-1:0] c;
    logic [COLQ_W-1:0] c2;
    logic [POS_W-1:0]  pos;
    logic [COLQ_W-1:0] set_c;
    logic [ROWQ_W-1:0] set_r;

    state_d    = state_q;
    after_d    = after_q;
    cnt_d      = cnt_q;
    fill_val_d = fill_val_q;
    col_d      = col_q;
    row_d      = row_q;
    curs_d     = curs_q;
    data_d     = data_q;
    cmd_d      = cmd_q;
    mem_req    = '0;
    r          = '0;
    r2         = '0;
    c          = '0;
    c2         = '0;
    pos        = '0;
    set_c      = '0;
    set_r      = '0;

    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          cmd_d   = cmd_in;
          state_d = ST_EXEC;
        end
      end

      ST_EXEC: begin
        unique case (cmd_q.operation)
          OP_PUT: begin
            data_d = '0;
            if ((col_q >= COLQ_W'(COLUMNS)) && (row_q == ROWQ_W'(ROWS - 1))) begin
              // Wrap off the bottom row: scroll first, then handle the character.
              col_d   = '0;
              cnt_d   = '0;
              after_d = ST_EXEC;
              state_d = ST_SCROLL;
            end else begin
              if (col_q >= COLQ_W'(COLUMNS)) begin
                r = {1'b0, row_q} + (ROWQ_W + 1)'(1);
                c = '0;
              end else begin
                r = {1'b0, row_q};
                c = col_q;
              end
              r2 = r;
              c2 = c;
              priority if (cmd_q.char_code == CODE_NEWLINE) begin
                c2 = '0;
                r2 = r + (ROWQ_W + 1)'(1);
              end else if (cmd_q.char_code == CODE_RETURN) begin
                c2 = '0;
              end else if (cmd_q.char_code >= CODE_SPACE) begin
                pos           = lin_pos(r, c);
                mem_req.we    = 1'b1;
                mem_req.waddr = ADDR_W'(pos);
                mem_req.wdata = {attr_i, cmd_q.char_code};
                c2            = c + COLQ_W'(1);
              end else begin
                c2 = c;
              end
              // The cursor register sees the position before the final scroll.
              curs_d = lin_pos(r2, c2);
              if (r2 == (ROWQ_W + 1)'(ROWS)) begin
                row_d   = ROWQ_W'(ROWS - 1);
                col_d   = '0;
                cnt_d   = '0;
                after_d = ST_RESP;
                state_d = ST_SCROLL;
              end else begin
                row_d   = r2[ROWQ_W-1:0];
                col_d   = c2;
                state_d = ST_RESP;
              end
            end
          end

          OP_SET: begin
            if (32'(cmd_q.cursor_column) >= COLUMNS) begin
              set_c = COLQ_W'(COLUMNS - 1);
            end else begin
              set_c = COLQ_W'(cmd_q.cursor_column);
            end
            if (32'(cmd_q.cursor_row) >= ROWS) begin
              set_r = ROWQ_W'(ROWS - 1);
            end else begin
              set_r = ROWQ_W'(cmd_q.cursor_row);
            end
            col_d   = set_c;
            row_d   = set_r;
            curs_d  = lin_pos({1'b0, set_r}, set_c);
            data_d  = '0;
            state_d = ST_RESP;
          end

          OP_CLEAR: begin
            col_d      = '0;
            row_d      = '0;
            data_d     = '0;
            cnt_d      = '0;
            fill_val_d = {attr_i, CODE_SPACE};
            after_d    = ST_RESP;
            state_d    = ST_FILL;
          end

          OP_READ: begin
            mem_req.re    = 1'b1;
            mem_req.raddr = ADDR_W'(cmd_q.cell_index);
            state_d       = ST_READ;
          end

          default: state_d = ST_RESP;
        endcase
      end

      // Move every row up by one: read ahead one row, write in the following cycle.
      ST_SCROLL: begin
        if (cnt_q < ADDR_W'(MOVE_COUNT)) begin
          mem_req.re    = 1'b1;
          mem_req.raddr = cnt_q + ADDR_W'(COLUMNS);
        end
        if (cnt_q != '0) begin
          mem_req.we    = 1'b1;
          mem_req.waddr = cnt_q - ADDR_W'(1);
          mem_req.wdata = rd_data_i;
        end
        if (cnt_q == ADDR_W'(MOVE_COUNT)) begin
          fill_val_d = {attr_i, CODE_SPACE};
          state_d    = ST_FILL;
        end else begin
          cnt_d = cnt_q + ADDR_W'(1);
        end
      end

      // Write the fill value from the counter up to the last cell.
      ST_FILL: begin
        mem_req.we    = 1'b1;
        mem_req.waddr = cnt_q;
        mem_req.wdata = fill_val_q;
        if (cnt_q == ADDR_W'(CELL_COUNT - 1)) begin
          state_d = after_q;
        end else begin
          cnt_d = cnt_q + ADDR_W'(1);
        end
      end

      ST_READ: begin
        if (cmd_q.cell_index < POS_W'(CELL_COUNT)) begin
          data_d = rd_data_i;
        end else begin
          data_d = '0;
        end
        state_d = ST_RESP;
      end

      ST_RESP: begin
        if (res_ready_i) begin
          if (accept) begin
            cmd_d   = cmd_in;
            state_d = ST_EXEC;
          end else begin
            state_d = ST_IDLE;
          end
        end
      end

      default: state_d = ST_IDLE;
    endcase
  end

  // State registers; reset starts the blanking pass over the whole screen.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_FILL;
      after_q    <= ST_IDLE;
      cnt_q      <= '0;
      fill_val_q <= {RESET_ATTR, CODE_SPACE};
      col_q      <= '0;
      row_q      <= '0;
      curs_q     <= '0;
    end else begin
      state_q    <= state_d;
      after_q    <= after_d;
      cnt_q      <= cnt_d;
      fill_val_q <= fill_val_d;
      col_q      <= col_d;
      row_q      <= row_d;
      curs_q     <= curs_d;
    end
  end

  // Request and result payload.
  always_ff @(posedge clk_i) begin
    cmd_q  <= cmd_d;
    data_q <= data_d;
  end

  assign mem_o                 = mem_req;
  assign res_valid_o           = (state_q == ST_RESP);
  assign res_o.cursor_position = curs_q;
  assign res_o.cell_data       = data_q;

  `TCW_ASSERT(a_pos_in_range, (state_q == ST_IDLE) |-> ((row_q < ROWQ_W'(ROWS)) && (col_q <= COLQ_W'(COLUMNS))), "cursor position out of range while idle")
  `TCW_ASSERT(a_waddr_in_range, mem_req.we |-> (mem_req.waddr < ADDR_W'(CELL_COUNT)), "cell write outside the screen")
  `TCW_ASSERT(a_no_same_cell, (mem_req.we && mem_req.re) |-> (mem_req.waddr != mem_req.raddr), "read and write of the same cell in one cycle")
  `TCW_ASSERT_NEXT(a_accept_exec, cmd_i.valid && cmd_ready, state_q == ST_EXEC, "accepted request not executed")

endmodule

// ===== design/text_console_writer.sv =====
// Text console writer: an 80 x 25 screen of 16-bit cells (attribute high byte, character
// low byte) held in one RAM with a registered read port, plus cursor and attribute
// registers. A put character, carriage return, newline or set cursor request passes
// through the sequencer's decode and result hand-off states, and a read cell request
// through decode, cell read and result hand-off. Clear screen writes one cell per cycle
// through the RAM write port. A scroll copies one cell per cycle (read one row ahead,
// write in the following cycle) and then blanks the bottom row; the scroll that a wrap
// off the bottom row forces comes before the character, which is decoded again
// afterwards. A put character request can cause up to two scrolls. After reset a
// blanking pass runs during which no request is accepted; attribute writes are taken
// at any time.
// The result register lets the next request be accepted while a result waits.
// Depends on tcw_pkg, tcw_if, tcw_ctrl and tcw_cell_ram.
module text_console_writer import tcw_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic [ATTR_W-1:0] cfg_data_i,
  tcw_cmd_if.sink           cmd_i,
  tcw_rsp_if.source         rsp_o
);

  logic [ATTR_W-1:0] attr_q;
  tcw_mem_req_t      mem_req;
  logic [CELL_W-1:0] rd_data;
  logic              res_valid;
  logic              res_ready;
  tcw_result_t       res;
  logic              out_valid_q;
  tcw_result_t       out_q;

  // Attribute register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      attr_q <= RESET_ATTR;
    end else if (cfg_we_i) begin
      attr_q <= cfg_data_i;
    end
  end

  tcw_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd_i),
    .attr_i      (attr_q),
    .mem_o       (mem_req),
    .rd_data_i   (rd_data),
    .res_valid_o (res_valid),
    .res_o       (res),
    .res_ready_i (res_ready)
  );

  tcw_cell_ram u_ram (
    .clk_i     (clk_i),
    .mem_i     (mem_req),
    .rd_data_o (rd_data)
  );

  // Result register between the sequencer and the result channel.
  assign res_ready = !out_valid_q || rsp_o.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_valid && res_ready) begin
      out_valid_q <= 1'b1;
    end else if (rsp_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_valid && res_ready) begin
      out_q <= res;
    end
  end

  assign rsp_o.valid           = out_valid_q;
  assign rsp_o.cursor_position = out_q.cursor_position;
  assign rsp_o.cell_data       = out_q.cell_data;

endmodule

// ===== dv/text_console_writer_tb.sv =====
// Self-checking testbench for the text console writer: random and directed requests
// are checked against a cycle-free shadow of the screen, cursor and attribute.
// Depends on tcw_pkg, tcw_if and the text_console_writer RTL.
module text_console_writer_tb import tcw_pkg::*; ();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CLK_PERIOD   = 20;
  localparam int RESET_CYCLES = 9;
  localparam int PHASE_ITEMS  = 200;
  // Quiet stretch between phases, about as long as a put that scrolls twice.
  localparam int SCROLL_SETTLE = 2 * 2001 + 200;
  localparam int DRAIN_CYCLES  = 50;

  logic              clk_i = 1'b0;
  logic              rst_ni;
  logic              cfg_we_i;
  logic [ATTR_W-1:0] cfg_data_i;

  tcw_cmd_if cmd_bus ();
  tcw_rsp_if rsp_bus ();

  text_console_writer uut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_data_i (cfg_data_i),
    .cmd_i      (cmd_bus),
    .rsp_o      (rsp_bus)
  );

  always #(CLK_PERIOD / 2) clk_i = ~clk_i;

  // Shadow copy of the console state.
  logic [CELL_W-1:0] shadow_screen [CELL_COUNT];
  int unsigned       shadow_col;
  int unsigned       shadow_row;
  logic [POS_W-1:0]  shadow_cursor;
  logic [ATTR_W-1:0] shadow_attr;

  tcw_cmd_t    request_backlog [$];
  tcw_result_t due_results [$];
  tcw_cmd_t    req_on_bus;
  int unsigned tx_gap, tx_calm, rx_hold, rx_calm;
  int unsigned fail_count = 0;

  // Fill the screen from a given cell on with blanks in the current attribute.
  function automatic void blank_from(int unsigned first);
    for (int unsigned i = first; i < CELL_COUNT; i++) begin
      shadow_screen[i] = {shadow_attr, CODE_SPACE};
    end
  endfunction

  // Once the row runs off the bottom, shift everything up one row.
  function automatic void scroll_if_off_screen();
    if (shadow_row >= ROWS) begin
      for (int unsigned i = 0; i < MOVE_COUNT; i++) begin
        shadow_screen[i] = shadow_screen[i + COLUMNS];
      end
      blank_from(MOVE_COUNT);
      shadow_row = ROWS - 1;
      shadow_col = 0;
    end
  endfunction

  function automatic void latch_cursor();
    shadow_cursor = POS_W'(shadow_row * COLUMNS + shadow_col);
  endfunction

  // Character output: pending wrap first, then the code itself, then the
  // cursor latch, and a scroll only after the cursor has been taken.
  function automatic void put_char(logic [CHAR_W-1:0] code);
    int unsigned addr;
    if (shadow_col >= COLUMNS) begin
      shadow_col = 0;
      shadow_row++;
      scroll_if_off_screen();
    end
    if (code == CODE_NEWLINE) begin
      shadow_col = 0;
      shadow_row++;
    end else if (code == CODE_RETURN) begin
      shadow_col = 0;
    end else if (code >= CODE_SPACE) begin
      addr = shadow_row * COLUMNS + shadow_col;
      if (addr < CELL_COUNT) begin
        shadow_screen[addr] = {shadow_attr, code};
      end
      shadow_col++;
    end
    latch_cursor();
    scroll_if_off_screen();
  endfunction

  // Apply one request to the shadow state and return the result it must produce.
  function automatic tcw_result_t console_step(tcw_cmd_t req);
    tcw_result_t res;
    res.cell_data = '0;
    case (req.operation)
      OP_PUT: begin
        put_char(req.char_code);
      end
      OP_SET: begin
        shadow_col = (req.cursor_column < COLUMNS) ? req.cursor_column : COLUMNS - 1;
        shadow_row = (req.cursor_row < ROWS) ? req.cursor_row : ROWS - 1;
        latch_cursor();
      end
      OP_CLEAR: begin
        blank_from(0);
        shadow_col = 0;
        shadow_row = 0;
      end
      default: begin
        if (req.cell_index < CELL_COUNT) begin
          res.cell_data = shadow_screen[req.cell_index];
        end
      end
    endcase
    res.cursor_position = shadow_cursor;
    return res;
  endfunction

  // Idle length: mostly none or short, a few long, and now and then a calm run.
  function automatic int unsigned draw_gap(inout int unsigned calm_left);
    int unsigned roll;
    if (calm_left > 0) begin
      calm_left--;
      return 0;
    end
    if ($urandom_range(40) == 0) begin
      calm_left = $urandom_range(60, 20);
      return 0;
    end
    roll = $urandom_range(99);
    if (roll < 50) return 0;
    if (roll < 88) return $urandom_range(3, 1);
    return $urandom_range(40, 6);
  endfunction

  // Random request; fields that the operation does not use stay random too.
  function automatic tcw_cmd_t random_request();
    tcw_cmd_t    req;
    int unsigned roll;
    int unsigned pick;
    req.char_code     = CHAR_W'($urandom);
    req.cursor_column = COL_W'($urandom);
    req.cursor_row    = ROW_W'($urandom);
    req.cell_index    = POS_W'($urandom);
    roll = $urandom_range(99);
    pick = $urandom_range(99);
    if (roll < 64) begin
      req.operation = OP_PUT;
      if (pick < 7) req.char_code = CODE_NEWLINE;
      else if (pick < 11) req.char_code = CODE_RETURN;
      else if (pick < 19) req.char_code = CHAR_W'($urandom_range(31));
      else req.char_code = CHAR_W'($urandom_range(255, 32));
    end else if (roll < 76) begin
      req.operation = OP_SET;
      if (pick < 80) req.cursor_column = COL_W'($urandom_range(COLUMNS - 1));
      if (pick < 75) req.cursor_row = ROW_W'($urandom_range(ROWS - 1));
    end else if (roll < 78) begin
      req.operation = OP_CLEAR;
    end else begin
      req.operation = OP_READ;
      if (pick < 85) req.cell_index = POS_W'($urandom_range(CELL_COUNT - 1));
    end
    return req;
  endfunction

  task automatic queue_request(tcw_op_e op, logic [CHAR_W-1:0] code,
                               logic [COL_W-1:0] col, logic [ROW_W-1:0] row,
                               logic [POS_W-1:0] idx);
    tcw_cmd_t req;
    req.operation     = op;
    req.char_code     = code;
    req.cursor_column = col;
    req.cursor_row    = row;
    req.cell_index    = idx;
    request_backlog.push_back(req);
  endtask

  task automatic queue_random(int unsigned count);
    repeat (count) request_backlog.push_back(random_request());
  endtask

  // Idle means nothing queued, nothing on the bus and no result outstanding.
  // Sampled at the falling edge, once the driver and monitor have settled.
  task automatic wait_idle();
    do begin
      @(negedge clk_i);
    end while (request_backlog.size() != 0 || cmd_bus.valid || due_results.size() != 0);
  endtask

  task automatic write_attribute(logic [ATTR_W-1:0] value);
    @(posedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_data_i <= value;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    shadow_attr = value;
  endtask

  // Request driver: predicts on acceptance and presents the next queued request.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cmd_bus.valid <= 1'b0;
      tx_gap  = 0;
      tx_calm = 0;
    end else begin
      if (cmd_bus.valid && cmd_bus.ready) begin
        due_results.push_back(console_step(req_on_bus));
      end
      if (!cmd_bus.valid || cmd_bus.ready) begin
        if (tx_gap > 0) begin
          tx_gap--;
          cmd_bus.valid <= 1'b0;
        end else if (request_backlog.size() > 0) begin
          req_on_bus = request_backlog.pop_front();
          cmd_bus.operation     <= req_on_bus.operation;
          cmd_bus.char_code     <= req_on_bus.char_code;
          cmd_bus.cursor_column <= req_on_bus.cursor_column;
          cmd_bus.cursor_row    <= req_on_bus.cursor_row;
          cmd_bus.cell_index    <= req_on_bus.cell_index;
          cmd_bus.valid         <= 1'b1;
          tx_gap = draw_gap(tx_calm);
        end else begin
          cmd_bus.valid <= 1'b0;
        end
      end
    end
  end

  // Result monitor: compares each accepted result with the oldest prediction.
  always @(posedge clk_i or negedge rst_ni) begin
    tcw_result_t want;
    if (!rst_ni) begin
      rsp_bus.ready <= 1'b0;
      rx_hold = 0;
      rx_calm = 0;
    end else begin
      if (rsp_bus.valid && rsp_bus.ready) begin
        if (due_results.size() == 0) begin
          $error("unexpected result: cursor_position %0d cell_data 0x%04h",
                 rsp_bus.cursor_position, rsp_bus.cell_data);
          fail_count++;
        end else begin
          want = due_results.pop_front();
          if (rsp_bus.cursor_position !== want.cursor_position) begin
            $error("cursor_position: expected %0d, actual %0d",
                   want.cursor_position, rsp_bus.cursor_position);
            fail_count++;
          end
          if (rsp_bus.cell_data !== want.cell_data) begin
            $error("cell_data: expected 0x%04h, actual 0x%04h",
                   want.cell_data, rsp_bus.cell_data);
            fail_count++;
          end
        end
        rx_hold = draw_gap(rx_calm);
      end else if (rsp_bus.ready && $urandom_range(15) == 0) begin
        rx_hold = draw_gap(rx_calm);
      end
      if (rx_hold > 0) begin
        rx_hold--;
        rsp_bus.ready <= 1'b0;
      end else begin
        rsp_bus.ready <= 1'b1;
      end
    end
  end

  // Stimulus: directed requests and a random phase at the reset attribute, then
  // further random phases, each under a new attribute written while the block is idle.
  initial begin
    logic [ATTR_W-1:0] attr_plan [5];
    attr_plan[0] = 8'h00;
    attr_plan[1] = 8'hFF;
    attr_plan[2] = ATTR_W'($urandom);
    attr_plan[3] = 8'h1F;
    attr_plan[4] = ATTR_W'($urandom);

    rst_ni                = 1'b0;
    cfg_we_i              = 1'b0;
    cfg_data_i            = '0;
    cmd_bus.valid         = 1'b0;
    cmd_bus.operation     = '0;
    cmd_bus.char_code     = '0;
    cmd_bus.cursor_column = '0;
    cmd_bus.cursor_row    = '0;
    cmd_bus.cell_index    = '0;
    rsp_bus.ready         = 1'b0;

    shadow_attr = RESET_ATTR;
    blank_from(0);
    shadow_col    = 0;
    shadow_row    = 0;
    shadow_cursor = '0;

    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Reset contents, last cell and reads past the end of the screen.
    queue_request(OP_READ, 8'h00, 7'd0, 5'd0, 11'd0);
    queue_request(OP_READ, 8'h00, 7'd0, 5'd0, 11'd1999);
    queue_request(OP_READ, 8'h00, 7'd0, 5'd0, 11'd2000);
    queue_request(OP_READ, 8'hFF, 7'h7F, 5'h1F, 11'h7FF);
    // Printable extremes, ignored control codes, return and newline.
    queue_request(OP_PUT, 8'h41, 7'd0, 5'd0, 11'd0);
    queue_request(OP_PUT, 8'h00, 7'd0, 5'd0, 11'd0);
    queue_request(OP_PUT, 8'h1F, 7'd0, 5'd0, 11'd0);
    queue_request(OP_PUT, 8'hFF, 7'd0, 5'd0, 11'd0);
    queue_request(OP_PUT, CODE_RETURN, 7'd0, 5'd0, 11'd0);
    queue_request(OP_PUT, CODE_NEWLINE, 7'd0, 5'd0, 11'd0);
    queue_request(OP_READ, 8'h00, 7'd0, 5'd0, 11'd0);
    queue_request(OP_READ, 8'h00, 7'd0, 5'd0, 11'd1);
    // Saturating cursor, then a wrap at the bottom followed by a newline: two scrolls.
    queue_request(OP_SET, 8'h00, 7'h7F, 5'h1F, 11'd0);
    queue_request(OP_PUT, 8'h7E, 7'd0, 5'd0, 11'd0);
    queue_request(OP_PUT, CODE_NEWLINE, 7'd0, 5'd0, 11'd0);
    // Last cell filled, then the next character wraps and scrolls first.
    queue_request(OP_SET, 8'h00, 7'd79, 5'd24, 11'd0);
    queue_request(OP_PUT, CODE_SPACE, 7'd0, 5'd0, 11'd0);
    queue_request(OP_PUT, 8'h42, 7'd0, 5'd0, 11'd0);
    queue_request(OP_READ, 8'h00, 7'd0, 5'd0, 11'd1920);
    queue_request(OP_READ, 8'h00, 7'd0, 5'd0, 11'd1839);
    // Clear with a cursor away from home, then read back.
    queue_request(OP_SET, 8'h00, 7'd40, 5'd12, 11'd0);
    queue_request(OP_CLEAR, 8'h00, 7'd0, 5'd0, 11'd0);
    queue_request(OP_READ, 8'h00, 7'd0, 5'd0, 11'd1000);
    queue_request(OP_PUT, 8'h5A, 7'd0, 5'd0, 11'd0);
    queue_request(OP_READ, 8'h00, 7'd0, 5'd0, 11'd0);
    queue_random(PHASE_ITEMS);

    foreach (attr_plan[p]) begin
      wait_idle();
      repeat (SCROLL_SETTLE) @(posedge clk_i);
      write_attribute(attr_plan[p]);
      queue_random(PHASE_ITEMS);
    end

    wait_idle();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("text_console_writer_tb passed");
    end else begin
      $display("text_console_writer_tb failed");
    end
    $finish;
  end

  // Watchdog: far beyond a run in which every request scrolls twice.
  initial begin
    #320ms;
    $display("text_console_writer_tb failed");
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+design
design/tcw_pkg.sv
design/tcw_if.sv
design/tcw_cell_ram.sv
design/tcw_ctrl.sv
design/text_console_writer.sv
dv/text_console_writer_tb.sv
